// ===== rtl/pmu_pkg.sv =====
// ----------------------------------------------------------------------------
// Particle motion update package
// Shared particle record, sine polynomial constants and fixed-point helpers.
// ----------------------------------------------------------------------------
package pmu_pkg;

   // Polynomial coefficients for a quarter wave of sine, Q16
   localparam logic [16:0] SIN_A   = 17'd102944;
   localparam logic [15:0] SIN_B   = 16'd42047;
   localparam logic [12:0] SIN_C   = 13'd4640;
   localparam logic [16:0] ONE_Q16 = 17'd65536;

   localparam logic [15:0] DT_RESET = 16'd1092;

   typedef struct packed {
      logic signed [31:0] accel;
      logic [30:0]        speed;
      logic signed [31:0] turn_rate;
      logic [15:0]        heading;
      logic signed [31:0] life_left;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_x;
   } particle_type;

   // Round a Q16 product to an integer, ties away from zero on the magnitude
   function automatic logic signed [33:0] round_q16(input logic signed [48:0] v);
      logic        neg;
      logic [48:0] mag;
      logic [48:0] sum;
      logic [32:0] r;
      neg = v[48];
      mag = neg ? 49'(-v) : 49'(v);
      sum = mag + 49'd32768;
      r   = sum[48:16];
      round_q16 = neg ? -$signed({1'b0, r}) : $signed({1'b0, r});
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [41:0] v);
      if (v > 42'sd2147483647) begin
         sat32 = 32'sh7FFF_FFFF;
      end else if (v < -42'sd2147483648) begin
         sat32 = 32'sh8000_0000;
      end else begin
         sat32 = v[31:0];
      end
   endfunction

endpackage

// ===== rtl/particle_motion_update_top.sv =====
// ----------------------------------------------------------------------------
// Particle motion update
// Advances one particle per beat by one time step with saturating Q16 math.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  carries one particle per beat; rsp_* returns the advanced particle.
//   csr_*  writes the time step (unsigned Q0.16 seconds); csr_ready is always
//   high, and the write should land only while no particle is in flight.
//   Live particles (life above zero) move along the heading using a polynomial
//   sine and cosine; dead ones pass unchanged with was_alive low.
// Each accepted request beat is registered in every stage in turn, the last
//   driving rsp_tvalid. Throughput: one particle per cycle while the receiver
//   does not stall; the six register stages follow the dependent multiplies
//   of the sine polynomial and the motion product.
// Reset clears every valid bit and loads the time step with 1092.
// When the receiver stalls, the whole pipeline holds; one more request beat is
//   caught in the skid register, then req_tready drops until the stall clears.
// ----------------------------------------------------------------------------
module particle_motion_update_top #(
   parameter int ANGLE_BITS = 16,
   parameter int FRAC_BITS  = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [15:0]  csr_data,      // time_step
   input  logic         req_tvalid,
   output logic         req_tready,
   // pos_x, pos_y, life_left, heading, turn_rate, speed, accel, zero pad
   input  logic [207:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // new_pos_x, new_pos_y, new_life_left, new_heading, new_speed, zero pad
   output logic [143:0] rsp_tdata,
   output logic [0:0]   rsp_tuser      // was_alive
);
   import pmu_pkg::*;

   localparam int HB = (ANGLE_BITS < 16) ? ANGLE_BITS : 16;
   localparam logic [15:0] HEAD_MASK = 16'((32'd1 << HB) - 32'd1);
   localparam int PHASE_SH = 32 - ANGLE_BITS;
   localparam int DT_UP = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
   localparam int DT_DN = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;

   typedef struct packed {
      particle_type       raw;
      logic               alive;
      logic signed [31:0] life_new;
      logic [15:0]        head_new;
      logic [30:0]        spd_new;
   } carry_type;

   logic en;
   assign en = !rsp_tvalid || rsp_tready;

   // ---------------- configuration ----------------
   logic [15:0] dt_ff;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         dt_ff <= DT_RESET;
      end else if (csr_valid && csr_ready) begin
         dt_ff <= csr_data;
      end
   end

   // ---------------- input skid ----------------
   particle_type port_item, skid_ff, src;
   logic         skid_full_ff, accept;

   assign port_item  = req_tdata[206:0];
   assign req_tready = !skid_full_ff;
   assign accept     = req_tvalid && req_tready;
   assign src        = skid_full_ff ? skid_ff : port_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_full_ff <= 1'b0;
      end else if (en) begin
         skid_full_ff <= 1'b0;
      end else if (accept) begin
         skid_full_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!en && accept) begin
         skid_ff <= port_item;
      end
   end

   // ---------------- stage 1: squares, step products, life ----------------
   logic [15:0]        head_m;
   logic [47:0]        phase_w;
   logic [31:0]        phase;
   logic [16:0]        xa_in, xb_in;
   logic [33:0]        sqa, sqb;
   logic signed [16:0] dt_s;
   logic signed [41:0] dtf, life_w;
   carry_type          c1_in;

   always_comb begin
      head_m  = src.heading & HEAD_MASK;
      phase_w = {32'b0, head_m} << PHASE_SH;
      phase   = phase_w[31:0];
      xa_in   = {1'b0, phase[29:14]};
      xb_in   = ONE_Q16 - xa_in;
      sqa     = xa_in * xa_in;
      sqb     = xb_in * xb_in;
      dt_s    = $signed({1'b0, dt_ff});
      dtf     = $signed((42'(dt_ff) << DT_UP) >> DT_DN);
      life_w  = 42'(src.life_left) - dtf;
      c1_in.raw         = src;
      c1_in.raw.heading = head_m;
      c1_in.alive       = src.life_left > 32'sd0;
      c1_in.life_new    = sat32(life_w);
      c1_in.head_new    = '0;
      c1_in.spd_new     = '0;
   end

   logic               v1_ff;
   carry_type          c1_ff;
   logic [1:0]         quad1_ff;
   logic [16:0]        xa1_ff, xb1_ff, x2a1_ff, x2b1_ff;
   logic [46:0]        spd_dt1_ff;
   logic signed [48:0] turn_p1_ff, acc_p1_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         c1_ff      <= c1_in;
         quad1_ff   <= phase[31:30];
         xa1_ff     <= xa_in;
         xb1_ff     <= xb_in;
         x2a1_ff    <= sqa[32:16];
         x2b1_ff    <= sqb[32:16];
         spd_dt1_ff <= src.speed * dt_ff;
         turn_p1_ff <= src.turn_rate * dt_s;
         acc_p1_ff  <= src.accel * dt_s;
      end
   end

   // ---------------- stage 2: inner term, heading and speed ----------------
   logic [29:0]        cqa, cqb;
   logic [15:0]        ta2_in, tb2_in;
   logic signed [33:0] turn_r, acc_r;
   logic signed [35:0] spd_w;
   carry_type          c2_in;

   always_comb begin
      cqa    = SIN_C * x2a1_ff;
      cqb    = SIN_C * x2b1_ff;
      ta2_in = SIN_B - 16'(cqa[29:16]);
      tb2_in = SIN_B - 16'(cqb[29:16]);
      turn_r = round_q16(turn_p1_ff);
      acc_r  = round_q16(acc_p1_ff);
      spd_w  = $signed({5'b0, c1_ff.raw.speed}) + 36'(acc_r);
      c2_in  = c1_ff;
      c2_in.head_new = (c1_ff.raw.heading + turn_r[15:0]) & HEAD_MASK;
      if (spd_w < 36'sd0) begin
         c2_in.spd_new = '0;
      end else if (spd_w > 36'sd2147483647) begin
         c2_in.spd_new = 31'h7FFF_FFFF;
      end else begin
         c2_in.spd_new = spd_w[30:0];
      end
   end

   logic        v2_ff;
   carry_type   c2_ff;
   logic [1:0]  quad2_ff;
   logic [16:0] xa2_ff, xb2_ff, x2a2_ff, x2b2_ff;
   logic [15:0] ta2_ff, tb2_ff;
   logic [46:0] spd_dt2_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         c2_ff      <= c2_in;
         quad2_ff   <= quad1_ff;
         xa2_ff     <= xa1_ff;
         xb2_ff     <= xb1_ff;
         x2a2_ff    <= x2a1_ff;
         x2b2_ff    <= x2b1_ff;
         ta2_ff     <= ta2_in;
         tb2_ff     <= tb2_in;
         spd_dt2_ff <= spd_dt1_ff;
      end
   end

   // ---------------- stage 3: middle term ----------------
   logic [32:0] pa3, pb3;
   logic [16:0] ta3_in, tb3_in;

   always_comb begin
      pa3    = ta2_ff * x2a2_ff;
      pb3    = tb2_ff * x2b2_ff;
      ta3_in = SIN_A - pa3[32:16];
      tb3_in = SIN_A - pb3[32:16];
   end

   logic        v3_ff;
   carry_type   c3_ff;
   logic [1:0]  quad3_ff;
   logic [16:0] xa3_ff, xb3_ff, ta3_ff, tb3_ff;
   logic [46:0] spd_dt3_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         c3_ff      <= c2_ff;
         quad3_ff   <= quad2_ff;
         xa3_ff     <= xa2_ff;
         xb3_ff     <= xb2_ff;
         ta3_ff     <= ta3_in;
         tb3_ff     <= tb3_in;
         spd_dt3_ff <= spd_dt2_ff;
      end
   end

   // ---------------- stage 4: outer term, quadrant select ----------------
   logic [33:0] pa4, pb4;
   logic [16:0] qa, qb;
   logic [1:0]  quad_c;
   logic [16:0] sm4_in, cm4_in;

   always_comb begin
      pa4    = ta3_ff * xa3_ff;
      pb4    = tb3_ff * xb3_ff;
      qa     = (pa4[33:16] > 18'(ONE_Q16)) ? ONE_Q16 : pa4[32:16];
      qb     = (pb4[33:16] > 18'(ONE_Q16)) ? ONE_Q16 : pb4[32:16];
      quad_c = quad3_ff + 2'd1;
      sm4_in = quad3_ff[0] ? qb : qa;
      cm4_in = quad_c[0] ? qb : qa;
   end

   logic        v4_ff;
   carry_type   c4_ff;
   logic [16:0] sm4_ff, cm4_ff;
   logic        sneg4_ff, cneg4_ff;
   logic [46:0] spd_dt4_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         c4_ff      <= c3_ff;
         sm4_ff     <= sm4_in;
         cm4_ff     <= cm4_in;
         sneg4_ff   <= quad3_ff[1];
         cneg4_ff   <= quad_c[1];
         spd_dt4_ff <= spd_dt3_ff;
      end
   end

   // ---------------- stage 5: motion products ----------------
   logic        v5_ff;
   carry_type   c5_ff;
   logic [63:0] mx5_ff, my5_ff;
   logic        sneg5_ff, cneg5_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         c5_ff    <= c4_ff;
         mx5_ff   <= 64'(spd_dt4_ff) * 64'(cm4_ff);
         my5_ff   <= 64'(spd_dt4_ff) * 64'(sm4_ff);
         sneg5_ff <= sneg4_ff;
         cneg5_ff <= cneg4_ff;
      end
   end

   // ---------------- stage 6: round, add, saturate, output ----------------
   logic [63:0]        rx_sum, ry_sum;
   logic signed [32:0] dx, dy;
   logic signed [41:0] px_w, py_w;
   logic signed [31:0] nx_in, ny_in, nl_in;
   logic [15:0]        nh_in;
   logic [30:0]        ns_in;

   always_comb begin
      rx_sum = mx5_ff + 64'h8000_0000;
      ry_sum = my5_ff + 64'h8000_0000;
      dx     = cneg5_ff ? -$signed({1'b0, rx_sum[63:32]}) : $signed({1'b0, rx_sum[63:32]});
      dy     = sneg5_ff ? -$signed({1'b0, ry_sum[63:32]}) : $signed({1'b0, ry_sum[63:32]});
      px_w   = 42'(c5_ff.raw.pos_x) + 42'(dx);
      py_w   = 42'(c5_ff.raw.pos_y) + 42'(dy);
      if (c5_ff.alive) begin
         nx_in = sat32(px_w);
         ny_in = sat32(py_w);
         nl_in = c5_ff.life_new;
         nh_in = c5_ff.head_new;
         ns_in = c5_ff.spd_new;
      end else begin
         nx_in = c5_ff.raw.pos_x;
         ny_in = c5_ff.raw.pos_y;
         nl_in = c5_ff.raw.life_left;
         nh_in = c5_ff.raw.heading;
         ns_in = c5_ff.raw.speed;
      end
   end

   logic [142:0] out_ff;
   logic         alive6_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         out_ff    <= {ns_in, nh_in, nl_in, ny_in, nx_in};
         alive6_ff <= c5_ff.alive;
      end
   end

   assign rsp_tdata = {1'b0, out_ff};
   assign rsp_tuser = alive6_ff;

   // ---------------- valid bits ----------------
   logic v6_ff;
   assign rsp_tvalid = v6_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= skid_full_ff || accept;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
      end
   end

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// Particle motion update testbench
// Streams particles through the block, predicts each advanced particle with
// an independent fixed-point model of the integration step and compares
// every returned beat field by field. Covers dead and live particles, field
// extremes, saturation and clamping, heading wrap, several time steps
// including both extremes, random idling on both sides and a long receiver
// hold-off that backs up the input.
// ----------------------------------------------------------------------------
module testbench;

   import pmu_pkg::particle_type;

   localparam int ANGLE_W         = 16;
   localparam int FRAC_W          = 16;
   localparam logic [15:0] RESET_STEP = 16'd1092;
   localparam longint unsigned QW_A   = 102944;
   localparam longint unsigned QW_B   = 42047;
   localparam longint unsigned QW_C   = 4640;
   localparam longint unsigned QW_ONE = 65536;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int WATCHDOG_LIMIT  = 5000;
   localparam int DRAIN_TAIL      = 16;
   localparam int STEP_CHUNK      = 120;

   typedef struct {
      logic [31:0] pos_x;
      logic [31:0] pos_y;
      logic [31:0] life;
      logic [15:0] heading;
      logic [30:0] speed;
      logic        alive;
   } motion_result_type;

   logic         clock      = 1'b0;
   logic         reset      = 1'b1;
   logic         csr_valid  = 1'b0;
   logic         csr_ready;
   logic [15:0]  csr_data   = '0;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [207:0] req_tdata  = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [143:0] rsp_tdata;
   logic [0:0]   rsp_tuser;

   motion_result_type pending_motion[$];
   logic [15:0]       step_setting = RESET_STEP;

   int send_idle_pct      = 0;
   int recv_idle_pct      = 0;
   bit hold_off_request   = 1'b0;
   int hold_left          = 0;
   int quiet_cycles       = 0;
   int particles_sent     = 0;
   int live_sent          = 0;
   int results_checked    = 0;
   int mismatch_count     = 0;
   int step_settings      = 0;
   int input_stall_cycles = 0;

   particle_motion_update_top #(
      .ANGLE_BITS(ANGLE_W),
      .FRAC_BITS (FRAC_W)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Fixed-point motion predictor
   // ---------------------------------------------------------------------
   function automatic longint nearest_q16(input longint v);
      bit              neg;
      longint unsigned mag;
      longint unsigned r;
      neg = v < 0;
      mag = neg ? -v : v;
      r   = (mag + 64'd32768) >> 16;
      return neg ? -longint'(r) : longint'(r);
   endfunction

   function automatic logic [31:0] clip32(input longint v);
      if (v > 64'sd2147483647) begin
         return 32'h7FFF_FFFF;
      end else if (v < -64'sd2147483648) begin
         return 32'h8000_0000;
      end
      return v[31:0];
   endfunction

   // sin(x * pi/2) for x in Q0.16, truncating polynomial
   function automatic longint unsigned quarter_wave(input longint unsigned x);
      longint unsigned x2;
      longint unsigned t;
      x2 = (x * x) >> 16;
      t  = (QW_C * x2) >> 16;
      t  = QW_B - t;
      t  = (t * x2) >> 16;
      t  = QW_A - t;
      t  = (t * x) >> 16;
      return (t > QW_ONE) ? QW_ONE : t;
   endfunction

   function automatic longint phase_wave(input logic [31:0] ph);
      longint unsigned z;
      longint unsigned s;
      z = ph[29:14];
      s = ph[30] ? quarter_wave(QW_ONE - z) : quarter_wave(z);
      return ph[31] ? -longint'(s) : longint'(s);
   endfunction

   function automatic longint travel(input longint unsigned spd, input longint unsigned dt,
                                     input longint trig);
      bit              neg;
      longint unsigned tm;
      longint unsigned r;
      neg = trig < 0;
      tm  = neg ? -trig : trig;
      r   = (spd * dt * tm + 64'h8000_0000) >> 32;
      return neg ? -longint'(r) : longint'(r);
   endfunction

   function automatic motion_result_type advance_particle(input particle_type p,
                                                          input logic [15:0] step);
      motion_result_type r;
      longint          px;
      longint          py;
      longint          life;
      longint          rate;
      longint          acc;
      longint          dt;
      longint          dtf;
      longint          turn;
      longint          ns;
      longint unsigned spd;
      longint unsigned head;
      longint unsigned amask;
      logic [31:0]     phase;
      amask = (64'd1 << ANGLE_W) - 1;
      px    = $signed(p.pos_x);
      py    = $signed(p.pos_y);
      life  = $signed(p.life_left);
      rate  = $signed(p.turn_rate);
      acc   = $signed(p.accel);
      spd   = p.speed;
      head  = p.heading & amask;
      dt    = step;
      if (life <= 0) begin
         r.pos_x   = p.pos_x;
         r.pos_y   = p.pos_y;
         r.life    = p.life_left;
         r.heading = head[15:0];
         r.speed   = p.speed;
         r.alive   = 1'b0;
         return r;
      end
      phase = 32'(head << (32 - ANGLE_W));
      // old heading and old speed drive the move
      px = px + travel(spd, dt, phase_wave(phase + 32'h4000_0000));
      py = py + travel(spd, dt, phase_wave(phase));
      if (FRAC_W >= 16) begin
         dtf = dt << (FRAC_W - 16);
      end else begin
         dtf = dt >> (16 - FRAC_W);
      end
      life = life - dtf;
      turn = nearest_q16(rate * dt);
      ns   = longint'(spd) + nearest_q16(acc * dt);
      if (ns < 0) begin
         ns = 0;
      end
      if (ns > 64'sh7FFF_FFFF) begin
         ns = 64'sh7FFF_FFFF;
      end
      r.pos_x   = clip32(px);
      r.pos_y   = clip32(py);
      r.life    = clip32(life);
      r.heading = 16'((head + turn) & amask);
      r.speed   = ns[30:0];
      r.alive   = 1'b1;
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   function automatic particle_type make_particle(input logic [31:0] x, input logic [31:0] y,
                                                  input logic [31:0] life,
                                                  input logic [15:0] head,
                                                  input logic [31:0] rate,
                                                  input logic [30:0] spd,
                                                  input logic [31:0] acc);
      particle_type p;
      p.pos_x     = x;
      p.pos_y     = y;
      p.life_left = life;
      p.heading   = head;
      p.turn_rate = rate;
      p.speed     = spd;
      p.accel     = acc;
      return p;
   endfunction

   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 7))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'($urandom_range(0, 4000)) - 32'd2000;
         default: return $urandom;
      endcase
   endfunction

   function automatic particle_type rand_particle();
      particle_type p;
      p.pos_x     = pick_word();
      p.pos_y     = pick_word();
      p.turn_rate = pick_word();
      p.accel     = pick_word();
      case ($urandom_range(0, 9))
         0: p.life_left = 32'd0;
         1: p.life_left = $urandom;
         2: p.life_left = 32'd1;
         3: p.life_left = 32'h7FFF_FFFF;
         4: p.life_left = 32'h8000_0000;
         default: p.life_left = $urandom_range(1, 32'h7FFF_FFFF);
      endcase
      case ($urandom_range(0, 7))
         0: p.heading = 16'h0000;
         1: p.heading = 16'h4000;
         2: p.heading = 16'h8000;
         3: p.heading = 16'hC000;
         4: p.heading = 16'hFFFF;
         default: p.heading = 16'($urandom);
      endcase
      case ($urandom_range(0, 5))
         0: p.speed = 31'd0;
         1: p.speed = 31'h7FFF_FFFF;
         2: p.speed = 31'($urandom_range(0, 32'h0010_0000));
         default: p.speed = 31'($urandom);
      endcase
      return p;
   endfunction

   function automatic logic [15:0] pick_step();
      case ($urandom_range(0, 5))
         0: return 16'd0;
         1: return 16'hFFFF;
         2: return 16'd1;
         3: return RESET_STEP;
         default: return 16'($urandom);
      endcase
   endfunction

   // Call at a rising edge; returns at the edge that takes the beat.
   task automatic send_particle(input particle_type p);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, p};
      do @(posedge clock); while (!req_tready);
      pending_motion.insert(pending_motion.size(), advance_particle(p, step_setting));
      particles_sent++;
      if ($signed(p.life_left) > 0) begin
         live_sent++;
      end
   endtask

   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      while (pending_motion.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // Only while nothing is in flight.
   task automatic write_time_step(input logic [15:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      step_setting = value;
      step_settings++;
      csr_valid <= 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------
   task automatic test_directed_particles();
      logic [15:0] quarter_heads[5];
      quarter_heads = '{16'h4000, 16'h8000, 16'hC000, 16'h2000, 16'hFFFF};
      // dead particles: zero life, most negative life, all ones
      send_particle(make_particle(0, 0, 0, 0, 0, 0, 0));
      send_particle(make_particle(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 16'hFFFF,
                                  32'h7FFF_FFFF, 31'h7FFF_FFFF, 32'h8000_0000));
      send_particle(make_particle('1, '1, '1, '1, '1, '1, '1));
      send_particle(make_particle(0, 0, 1, 0, 0, 31'h0001_0000, 0));
      foreach (quarter_heads[i]) begin
         send_particle(make_particle(0, 0, 32'h0001_0000, quarter_heads[i], 0,
                                     31'h7FFF_FFFF, 0));
      end
      // saturate positions on each edge, clamp speed at both ends, wrap heading
      send_particle(make_particle(32'h7FFF_FF00, 0, 32'h7FFF_FFFF, 16'h0000, 0,
                                  31'h7FFF_FFFF, 32'h7FFF_FFFF));
      send_particle(make_particle(32'h8000_0100, 0, 32'h7FFF_FFFF, 16'h8000, 0,
                                  31'h7FFF_FFFF, 0));
      send_particle(make_particle(0, 32'h7FFF_FF00, 32'h7FFF_FFFF, 16'h4000, 32'h7FFF_FFFF,
                                  31'h7FFF_FFFF, 0));
      send_particle(make_particle(0, 32'h8000_0100, 32'h7FFF_FFFF, 16'hC000, 32'h8000_0000,
                                  31'h7FFF_FFFF, 0));
      send_particle(make_particle(0, 0, 32'h7FFF_FFFF, 16'h1234, 0, 31'h100, 32'h8000_0000));
      send_particle(make_particle(32'h1234_5678, 32'h9ABC_DEF0, 32'h8000, 16'h0001,
                                  32'h0001_0000, 31'd1, 32'd1));
      send_particle(make_particle(0, 0, 32'h444, 16'h3FFF, 32'hFFFF_0000, 31'h0005_0000,
                                  32'hFFFF_8000));
      wait_for_results();
   endtask

   task automatic test_time_step_extremes();
      write_time_step(16'hFFFF);
      send_particle(make_particle(32'h7FFF_FFFF, 32'h8000_0000, 32'd1, 16'h2000, 32'h7FFF_FFFF,
                                  31'h7FFF_FFFF, 32'h7FFF_FFFF));
      send_particle(make_particle(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hA000,
                                  32'h8000_0000, 31'h7FFF_FFFF, 32'h8000_0000));
      send_particle(make_particle(0, 0, 32'h0000_FFFF, 16'h6000, 0, 31'h4000_0000, 0));
      repeat (2) send_particle(rand_particle());
      wait_for_results();
      write_time_step(16'd0);
      send_particle(make_particle(32'h7FFF_FFFF, 0, 32'd1, 16'h2000, 32'h7FFF_FFFF,
                                  31'h7FFF_FFFF, 32'h7FFF_FFFF));
      repeat (2) send_particle(rand_particle());
      wait_for_results();
      write_time_step(16'd1);
      send_particle(make_particle(0, 0, 32'd1, 16'hE000, 32'h0000_8000, 31'h7FFF_FFFF,
                                  32'hFFFF_8000));
      send_particle(rand_particle());
      wait_for_results();
   endtask

   task automatic test_input_stall();
      send_idle_pct    = 0;
      recv_idle_pct    = 0;
      hold_off_request = 1'b1;
      // keep offering beats while the receiver holds off; the block backs up
      repeat (40) send_particle(rand_particle());
      wait_for_results();
   endtask

   task automatic test_random_particles(input int count, input int send_pct,
                                        input int recv_pct);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      for (int i = 0; i < count; i++) begin
         if (i % STEP_CHUNK == 0) begin
            wait_for_results();
            write_time_step(pick_step());
         end
         send_particle(rand_particle());
      end
      wait_for_results();
   endtask

   // ---------------------------------------------------------------------
   // Receiver, result check and watchdog
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left = hold_left - 1;
      end else if (hold_off_request) begin
         hold_off_request = 1'b0;
         hold_left = HOLD_OFF_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         mismatch_count++;
         if (mismatch_count <= 10) begin
            $display("result %0d: %s expected %h, got %h", results_checked, name, want, got);
         end
      end
   endtask

   always @(posedge clock) begin : check_result
      motion_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_motion.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $display("result beat with nothing pending: data %h alive %b",
                        rsp_tdata, rsp_tuser);
            end
         end else begin
            want = pending_motion.pop_front();
            compare_field("new_pos_x", want.pos_x, rsp_tdata[31:0]);
            compare_field("new_pos_y", want.pos_y, rsp_tdata[63:32]);
            compare_field("new_life_left", want.life, rsp_tdata[95:64]);
            compare_field("new_heading", 32'(want.heading), 32'(rsp_tdata[111:96]));
            compare_field("new_speed", 32'(want.speed), 32'(rsp_tdata[142:112]));
            compare_field("was_alive", 32'(want.alive), 32'(rsp_tuser[0]));
         end
         results_checked++;
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles = quiet_cycles + 1;
      end
      if (!reset && req_tvalid && !req_tready) begin
         input_stall_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("particle_motion_update_top test failed");
         $finish;
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_idle_pct = 31;
      recv_idle_pct = 54;
      test_directed_particles();
      test_time_step_extremes();
      test_random_particles(480, 31, 54);
      test_random_particles(480, 54, 31);
      test_input_stall();
      test_random_particles(480, 0, 0);
      wait_for_results();
      repeat (DRAIN_TAIL) @(posedge clock);
      if (pending_motion.size() != 0) begin
         $display("%0d expected results never arrived", pending_motion.size());
         mismatch_count += pending_motion.size();
      end
      $display("sent %0d particles (%0d live, %0d dead) under %0d time step writes",
               particles_sent, live_sent, particles_sent - live_sent, step_settings);
      $display("checked %0d results, %0d mismatches, input stalled %0d cycles",
               results_checked, mismatch_count, input_stall_cycles);
      if (mismatch_count == 0) begin
         $display("particle_motion_update_top test passed");
      end else begin
         $display("particle_motion_update_top test failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/pmu_pkg.sv
rtl/particle_motion_update_top.sv
bench/testbench.sv
